// File: rtl/plist_pkg.sv
`default_nettype none

package plist_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int CMP_W    = POS_W + 1;
    localparam int DATA_W   = 32;
    localparam int WORD_W   = 2 * DATA_W;

    localparam logic [1:0] MODE_GET    = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] entry_id;
        logic [DATA_W-1:0] entry_price;
    } plist_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] out_id;
        logic [DATA_W-1:0] out_price;
        logic [7:0]        entry_count;
    } plist_out_t;

    typedef struct packed {
        logic load;
        logic init_ptr;
        logic rd;
        logic put_new;
        logic finish;
    } plist_cmd_t;

    typedef struct packed {
        logic bad;
        logic full;
        logic is_ins;
        logic no_move;
        logic last;
        logic out_free;
    } plist_sts_t;

endpackage

`default_nettype wire

// File: rtl/positional_list_insert_delete_unit.sv
// An insert or delete moves n entries (up to 127) through the memory, one word per cycle; a get
// moves none, an insert at the end writes the new entry without moving any, and an item rejected
// for position or a full list moves nothing. A new item is taken only once the previous one has
// been loaded into the output register, and it is taken while that result waits. Reset (aresetn,
// synchronous, active low) empties the list and drops any pending result; the entry memory itself
// is not cleared.
`default_nettype none

module positional_list_insert_delete_unit import plist_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire plist_in_t s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output plist_out_t     m_data
);

    plist_cmd_t cmd;
    plist_sts_t sts;

    plist_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    plist_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// File: rtl/plist_ctrl.sv
`default_nettype none

module plist_ctrl import plist_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire plist_sts_t sts,
    output plist_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.bad || sts.full) begin
                    state_next = S_DONE;
                end else begin
                    cmd.init_ptr = 1'b1;
                    if (sts.is_ins && sts.no_move) begin
                        state_next = S_PUT;
                    end else begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN: begin
                cmd.rd = 1'b1;
                if (sts.last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = sts.is_ins ? S_PUT : S_DONE;
            end
            S_PUT: begin
                cmd.put_new = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_CHECK)
        else $error("accepted transfer did not start a check");

    a_finish_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> sts.out_free)
        else $error("result loaded while output register busy");

    a_one_mem_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put_new |-> !cmd.rd && !cmd.init_ptr)
        else $error("new entry written during shift");
`endif

endmodule

`default_nettype wire

// File: rtl/plist_dp.sv
`default_nettype none

module plist_dp import plist_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire plist_in_t  s_data,
    input  wire plist_cmd_t cmd,
    output plist_sts_t      sts,
    output logic            m_valid,
    input  wire logic       m_ready,
    output plist_out_t      m_data
);

    logic [WORD_W-1:0] mem [CAPACITY];

    plist_in_t         in_reg;
    plist_in_t         in_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] rd_addr_next;
    logic              pend_reg;
    logic              pend_next;
    logic              first_reg;
    logic              first_next;
    logic [WORD_W-1:0] rdata_reg;
    logic [WORD_W-1:0] cap_reg;
    logic [WORD_W-1:0] cap_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    plist_out_t        m_data_reg;
    plist_out_t        m_data_next;

    logic              is_get;
    logic              is_ins;
    logic              is_del;
    logic              bad;
    logic              full;
    logic              ok;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  fill_ext;
    logic [CMP_W-1:0]  fill_p1;
    logic [ADDR_W-1:0] pos_addr;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              pend_wr;

    always_comb begin
        is_get   = (in_reg.mode == MODE_GET);
        is_ins   = (in_reg.mode == MODE_INSERT);
        is_del   = (in_reg.mode == MODE_DELETE);
        pos_ext  = CMP_W'(in_reg.position);
        fill_ext = CMP_W'(fill_reg);
        fill_p1  = fill_ext + CMP_W'(1);
        bad      = (in_reg.position == '0)
                   || (is_ins ? (pos_ext > fill_p1) : (pos_ext > fill_ext))
                   || !(is_get || is_ins || is_del);
        full     = is_ins && !bad && (fill_reg == CNT_W'(CAPACITY));
        ok       = !bad && !full;
        pos_addr = ADDR_W'(in_reg.position - POS_W'(1));
        top_addr = ADDR_W'(fill_reg - CNT_W'(1));
        end_addr = is_del ? top_addr : pos_addr;
        wr_addr  = is_ins ? (rd_addr_reg + ADDR_W'(1)) : (rd_addr_reg - ADDR_W'(1));
        pend_wr  = pend_reg && (is_ins || !first_reg);
    end

    always_comb begin
        sts.bad      = bad;
        sts.full     = full;
        sts.is_ins   = is_ins;
        sts.no_move  = (pos_ext == fill_p1);
        sts.last     = (ptr_reg == end_addr);
        sts.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        in_next      = cmd.load ? s_data : in_reg;
        ptr_next     = ptr_reg;
        rd_addr_next = rd_addr_reg;
        pend_next    = cmd.rd;
        first_next   = first_reg;
        cap_next     = cap_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (cmd.init_ptr) begin
            ptr_next   = is_ins ? top_addr : pos_addr;
            first_next = 1'b1;
        end else if (pend_reg) begin
            first_next = 1'b0;
        end
        if (cmd.rd) begin
            rd_addr_next = ptr_reg;
            ptr_next     = is_ins ? (ptr_reg - ADDR_W'(1)) : (ptr_reg + ADDR_W'(1));
        end
        if (pend_reg && first_reg && !is_ins) begin
            cap_next = rdata_reg;
        end

        if (cmd.finish) begin
            if (ok && is_ins) begin
                fill_next = fill_reg + CNT_W'(1);
            end else if (ok && is_del) begin
                fill_next = fill_reg - CNT_W'(1);
            end
            m_valid_next = 1'b1;
            if (bad) begin
                m_data_next.status = ST_BADPOS;
            end else if (full) begin
                m_data_next.status = ST_FULL;
            end else begin
                m_data_next.status = ST_OK;
            end
            if (ok && !is_ins) begin
                m_data_next.out_id    = cap_reg[WORD_W-1:DATA_W];
                m_data_next.out_price = cap_reg[DATA_W-1:0];
            end else begin
                m_data_next.out_id    = '0;
                m_data_next.out_price = '0;
            end
            m_data_next.entry_count = 8'(fill_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put_new) begin
            mem[pos_addr] <= {in_reg.entry_id, in_reg.entry_price};
        end else if (pend_wr) begin
            mem[wr_addr] <= rdata_reg;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        ptr_reg     <= ptr_next;
        rd_addr_reg <= rd_addr_next;
        cap_reg     <= cap_next;
        m_data_reg  <= m_data_next;
        if (!aresetn) begin
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.put_new && pend_wr))
        else $error("two memory writes in one cycle");

    a_count_on_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg && (m_data_reg.entry_count == 8'(fill_reg)))
        else $error("result count differs from list count");
`endif

endmodule

`default_nettype wire

// File: dv/positional_list_insert_delete_unit_tb.sv
`timescale 1ns / 100ps

module positional_list_insert_delete_unit_tb;
    import plist_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    plist_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    plist_out_t m_data;

    logic [DATA_W-1:0] list_id    [CAPACITY];
    logic [DATA_W-1:0] list_price [CAPACITY];
    int unsigned       list_fill = 0;
    int unsigned       peak_fill = 0;
    plist_out_t        pending_results[$];
    plist_out_t        want;

    bit idle_on     = 1'b1;
    int err_count   = 0;
    int idle_cycles = 0;
    int n_get = 0, n_insert = 0, n_delete = 0, n_other = 0;
    int n_ok = 0, n_badpos = 0, n_full = 0;

    positional_list_insert_delete_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic plist_out_t list_apply(plist_in_t op);
        plist_out_t r;
        int pos;
        int i;
        r        = '0;
        r.status = ST_BADPOS;
        pos      = op.position;
        case (op.mode)
            MODE_GET: begin
                if (pos >= 1 && pos <= list_fill) begin
                    r.status    = ST_OK;
                    r.out_id    = list_id[pos-1];
                    r.out_price = list_price[pos-1];
                end
            end
            MODE_INSERT: begin
                if (pos >= 1 && pos <= list_fill + 1) begin
                    if (list_fill >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        for (i = list_fill; i >= pos; i--) begin
                            list_id[i]    = list_id[i-1];
                            list_price[i] = list_price[i-1];
                        end
                        list_id[pos-1]    = op.entry_id;
                        list_price[pos-1] = op.entry_price;
                        list_fill++;
                        r.status = ST_OK;
                    end
                end
            end
            MODE_DELETE: begin
                if (pos >= 1 && pos <= list_fill) begin
                    r.status    = ST_OK;
                    r.out_id    = list_id[pos-1];
                    r.out_price = list_price[pos-1];
                    for (i = pos; i < list_fill; i++) begin
                        list_id[i-1]    = list_id[i];
                        list_price[i-1] = list_price[i];
                    end
                    list_fill--;
                end
            end
            default: begin
            end
        endcase
        r.entry_count = 8'(list_fill);
        return r;
    endfunction

    function automatic plist_in_t make_op(logic [1:0] mode, int pos,
                                          logic [31:0] id, logic [31:0] price);
        plist_in_t op;
        op.mode        = mode;
        op.position    = 8'(pos);
        op.entry_id    = id;
        op.entry_price = price;
        return op;
    endfunction

    // Mostly well-formed operations aimed at occupied positions, with some noise.
    function automatic plist_in_t random_op(int insert_pct);
        plist_in_t op;
        int roll;
        op.entry_id    = $urandom;
        op.entry_price = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            op.mode     = 2'($urandom_range(0, 3));
            op.position = 8'($urandom_range(0, 255));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) begin
                op.mode = MODE_INSERT;
            end else if (roll < insert_pct + (100 - insert_pct) / 2) begin
                op.mode = MODE_DELETE;
            end else begin
                op.mode = MODE_GET;
            end
            if (op.mode == MODE_INSERT) begin
                op.position = 8'($urandom_range(1, list_fill + 1));
            end else if (list_fill == 0) begin
                op.position = 8'($urandom_range(0, 2));
            end else begin
                op.position = 8'($urandom_range(1, list_fill));
            end
        end
        return op;
    endfunction

    task automatic send_item(plist_in_t item);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!(s_valid && s_ready));
        case (item.mode)
            MODE_GET:    n_get++;
            MODE_INSERT: n_insert++;
            MODE_DELETE: n_delete++;
            default:     n_other++;
        endcase
        pending_results.push_back(list_apply(item));
        if (list_fill > peak_fill) peak_fill = list_fill;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(make_op(MODE_GET, 1, 32'h0, 32'h0));
        send_item(make_op(MODE_DELETE, 1, 32'h0, 32'h0));
        send_item(make_op(MODE_INSERT, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_op(MODE_INSERT, 2, 32'h1111_1111, 32'h2222_2222));
        send_item(make_op(MODE_INSERT, 255, 32'h3333_3333, 32'h4444_4444));
        send_item(make_op(MODE_INSERT, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_op(MODE_INSERT, 1, 32'h0, 32'h0));
        send_item(make_op(MODE_INSERT, 3, 32'h1234_5678, 32'h8000_0000));
        send_item(make_op(MODE_INSERT, 2, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        send_item(make_op(MODE_GET, 0, 32'h0, 32'h0));
        send_item(make_op(MODE_GET, 1, 32'h0, 32'h0));
        send_item(make_op(MODE_GET, 4, 32'h0, 32'h0));
        send_item(make_op(MODE_GET, 5, 32'h0, 32'h0));
        send_item(make_op(MODE_GET, 255, 32'h0, 32'h0));
        send_item(make_op(2'd3, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_op(2'd3, 255, 32'h0, 32'h0));
        send_item(make_op(MODE_DELETE, 0, 32'h0, 32'h0));
        send_item(make_op(MODE_DELETE, 5, 32'h0, 32'h0));
        send_item(make_op(MODE_DELETE, 2, 32'h0, 32'h0));
        send_item(make_op(MODE_DELETE, 3, 32'h0, 32'h0));
        send_item(make_op(MODE_DELETE, 1, 32'h0, 32'h0));
        send_item(make_op(MODE_GET, 1, 32'h0, 32'h0));
        send_item(make_op(MODE_DELETE, 1, 32'h0, 32'h0));
        send_item(make_op(MODE_DELETE, 1, 32'h0, 32'h0));
    endtask

    task automatic test_full_list();
        while (list_fill < CAPACITY) begin
            send_item(make_op(MODE_INSERT, $urandom_range(1, list_fill + 1),
                              $urandom, $urandom));
        end
        send_item(make_op(MODE_INSERT, CAPACITY + 1, $urandom, $urandom));
        send_item(make_op(MODE_INSERT, 1, $urandom, $urandom));
        send_item(make_op(MODE_INSERT, CAPACITY / 2, $urandom, $urandom));
        send_item(make_op(MODE_INSERT, CAPACITY + 2, $urandom, $urandom));
        send_item(make_op(MODE_INSERT, 0, $urandom, $urandom));
        send_item(make_op(MODE_GET, CAPACITY, 32'h0, 32'h0));
        send_item(make_op(MODE_GET, CAPACITY + 1, 32'h0, 32'h0));
        send_item(make_op(MODE_DELETE, CAPACITY, 32'h0, 32'h0));
        send_item(make_op(MODE_INSERT, CAPACITY, $urandom, $urandom));
        send_item(make_op(MODE_DELETE, 1, 32'h0, 32'h0));
        send_item(make_op(MODE_GET, 255, 32'h0, 32'h0));
        // The sender holds off here until the block has returned everything.
        wait_drained();
    endtask

    task automatic test_random_mix(int count, int insert_pct);
        repeat (count) send_item(random_op(insert_pct));
    endtask

    task automatic test_quiet_tail(int count);
        idle_on = 1'b0;
        test_random_mix(count, 50);
    endtask

    task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending, expected none, actual %h",
                         $time, m_data);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("status", 32'(want.status), 32'(m_data.status));
                report_field("out_id", want.out_id, m_data.out_id);
                report_field("out_price", want.out_price, m_data.out_price);
                report_field("entry_count", 32'(want.entry_count), 32'(m_data.entry_count));
                case (want.status)
                    ST_OK:     n_ok++;
                    ST_BADPOS: n_badpos++;
                    default:   n_full++;
                endcase
            end
        end
    end

    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("[positional_list_insert_delete_unit] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_list();
        test_random_mix(300, 65);
        test_random_mix(300, 20);
        test_random_mix(250, 50);
        test_quiet_tail(200);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d gets, %0d inserts, %0d deletes and %0d unused-mode items.",
                 n_get, n_insert, n_delete, n_other);
        $display("Results: %0d ok, %0d bad position, %0d list full; peak fill %0d.",
                 n_ok, n_badpos, n_full, peak_fill);
        if (err_count == 0) begin
            $display("[positional_list_insert_delete_unit] OK");
        end else begin
            $display("[positional_list_insert_delete_unit] ERROR");
        end
        $finish;
    end

endmodule
